// ===== rtl/core/ffha_pkg.sv =====
// Shared function and status codes for the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

  // Request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_if.sv =====
// Request and response channel interfaces of the heap allocator.
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if #(
  parameter int AW = 12,
  parameter int LW = 13
);
  logic          valid;
  logic          ready;
  logic          func;
  logic [LW-1:0] req_size;
  logic [AW-1:0] ptr_addr;

  modport source (output valid, func, req_size, ptr_addr, input ready);
  modport sink   (input valid, func, req_size, ptr_addr, output ready);
endinterface

interface ffha_rsp_if #(
  parameter int AW = 12
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [AW-1:0] payload_addr;

  modport source (output valid, status, payload_addr, input ready);
  modport sink   (input valid, status, payload_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic                 re_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator with coalescing: sequencer over two RAMs.
//
// Usage: requests arrive on req_i (valid/ready); func selects allocate or
// free. Each request yields exactly one item on rsp_o with a status and,
// for a successful allocate, the payload address (header skipped).
// The free-segment table (start, length) lives in one RAM of MAX_SEGS
// entries, kept sorted by address; block lengths live in a second RAM of
// HEAP_UNITS entries indexed by block start.
// Sequence: an allocate scans the table one entry per cycle until the first
// fit, plus a shift-down of the remaining entries when a segment is used up.
// A free reads the length RAM, scans to the insertion point, then may shift
// the tail up or down one entry per cycle. The single table RAM port pair
// paces both; one request is in work at a time.
// Reset: the table holds one segment covering the heap, without a clearing
// pass; the length RAM is not cleared.
// Stall: a finished item waits in the output register; req_i is ready again
// as soon as the sequencer is idle, and the next result waits until rsp_o
// drains.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator_top #(
  parameter int HEAP_UNITS   = 4096,
  parameter int MAX_SEGS     = 64,
  parameter int HEADER_UNITS = 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffha_req_if.sink  req_i,
  ffha_rsp_if.source rsp_o
);
  localparam int AW = $clog2(HEAP_UNITS);
  localparam int LW = $clog2(HEAP_UNITS + 1);
  localparam int IW = $clog2(MAX_SEGS);
  localparam int CW = $clog2(MAX_SEGS + 1);
  localparam int SW = AW + LW;

  localparam logic [LW:0]   HDR  = (LW+1)'(HEADER_UNITS);
  localparam logic [LW:0]   HEAP = (LW+1)'(HEAP_UNITS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_FLEN  = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_SHDN  = 3'd4;
  localparam logic [2:0] S_SHUP  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rdi_q, rdi_d;
  logic [CW-1:0] hit_q, hit_d;
  logic          pend_q, pend_d;
  logic          more_q, more_d;
  logic          rd0_q, rd0_d;
  logic          seg0_wr_q;
  logic [LW:0]   need_q, need_d;
  logic [AW-1:0] bs_q, bs_d;
  logic [LW-1:0] len_q, len_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] ps_q, ps_d;
  logic [LW-1:0] pl_q, pl_d;
  logic [1:0]    rst_q, rst_d;
  logic [AW-1:0] radr_q, radr_d;
  logic          ov_q;
  logic [1:0]    ost_q;
  logic [AW-1:0] oadr_q;

  // Table RAM ports
  logic          seg_re, seg_we;
  logic [IW-1:0] seg_ra, seg_wa;
  logic [SW-1:0] seg_wd, seg_rd;
  // Length RAM ports
  logic          al_re, al_we;
  logic [AW-1:0] al_ra, al_wa;
  logic [LW-1:0] al_wd, al_rd;

  logic [AW-1:0] cur_s;
  logic [LW-1:0] cur_l;

  // Working values
  logic [LW:0]   req_n, left, cap, lenc, endb, pe;
  logic [AW-1:0] bs_in;
  logic          geq, has_cur, ev_pv, bad, mp, mn;
  logic [AW-1:0] e_ps;
  logic [LW-1:0] e_pl;
  logic [CW-1:0] ins_i, prv_i;

  ffha_ram #(.W(SW), .D(MAX_SEGS)) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_wa),
    .wdata_i(seg_wd),
    .re_i   (seg_re),
    .raddr_i(seg_ra),
    .rdata_o(seg_rd)
  );

  ffha_ram #(.W(LW), .D(HEAP_UNITS)) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (al_we),
    .waddr_i(al_wa),
    .wdata_i(al_wd),
    .re_i   (al_re),
    .raddr_i(al_ra),
    .rdata_o(al_rd)
  );

  // Entry 0 reads as the whole heap until it is first written
  always_comb begin
    if (rd0_q) begin
      cur_s = '0;
      cur_l = HEAP[LW-1:0];
    end else begin
      cur_s = seg_rd[SW-1:LW];
      cur_l = seg_rd[LW-1:0];
    end
  end

  assign req_i.ready        = (st_q == S_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = ost_q;
  assign rsp_o.payload_addr = oadr_q;

  // Shared arithmetic
  always_comb begin
    req_n   = (req_i.req_size == '0) ? (LW+1)'(1) : {1'b0, req_i.req_size};
    bs_in   = req_i.ptr_addr - AW'(HEADER_UNITS);
    left    = {1'b0, cur_l} - need_q;
    cap     = HEAP - {1'b0, bs_q};
    lenc    = ({1'b0, al_rd} > cap) ? cap : {1'b0, al_rd};
    endb    = {1'b0, bs_q} + {1'b0, len_q};
    geq     = ({1'b0, cur_s} >= {1'b0, bs_q});
    has_cur = pend_q && geq;
    ev_pv   = (pend_q && !geq) ? 1'b1 : pv_q;
    e_ps    = (pend_q && !geq) ? cur_s : ps_q;
    e_pl    = (pend_q && !geq) ? cur_l : pl_q;
    pe      = {1'b0, e_ps} + {1'b0, e_pl};
    bad     = (ev_pv && pe > {1'b0, bs_q}) ||
              (has_cur && endb > {1'b0, cur_s});
    mp      = ev_pv && (pe == {1'b0, bs_q});
    mn      = has_cur && ({1'b0, cur_s} == endb);
    ins_i   = has_cur ? rdi_q : cnt_q;
    prv_i   = ins_i - CW'(1);
  end

  // Sequencer
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    rdi_d  = rdi_q;
    hit_d  = hit_q;
    pend_d = 1'b0;
    more_d = more_q;
    need_d = need_q;
    bs_d   = bs_q;
    len_d  = len_q;
    pv_d   = pv_q;
    ps_d   = ps_q;
    pl_d   = pl_q;
    rst_d  = rst_q;
    radr_d = radr_q;
    seg_re = 1'b0;
    seg_ra = idx_q[IW-1:0];
    seg_we = 1'b0;
    seg_wa = '0;
    seg_wd = '0;
    al_re  = 1'b0;
    al_ra  = bs_in;
    al_we  = 1'b0;
    al_wa  = cur_s;
    al_wd  = '0;

    unique case (st_q)
      S_IDLE: begin
        if (req_i.valid) begin
          idx_d  = '0;
          pv_d   = 1'b0;
          radr_d = '0;
          if (req_i.func == ffha_pkg::FUNC_ALLOC) begin
            need_d = req_n + HDR;
            st_d   = S_ASCAN;
          end else if ({1'b0, req_i.ptr_addr} < HDR ||
                       {1'b0, req_i.ptr_addr} >= HEAP) begin
            rst_d = ffha_pkg::ST_BADADDR;
            st_d  = S_FIN;
          end else begin
            bs_d  = bs_in;
            al_re = 1'b1;
            st_d  = S_FLEN;
          end
        end
      end

      S_ASCAN: begin
        if (pend_q && ({1'b0, cur_l} >= need_q)) begin
          // Take the first fitting segment
          al_we  = 1'b1;
          rst_d  = ffha_pkg::ST_OK;
          radr_d = cur_s + AW'(HEADER_UNITS);
          if (left > HDR) begin
            seg_we = 1'b1;
            seg_wa = rdi_q[IW-1:0];
            seg_wd = {cur_s + need_q[AW-1:0], left[LW-1:0]};
            al_wd  = need_q[LW-1:0];
            st_d   = S_FIN;
          end else begin
            al_wd = cur_l;
            idx_d = rdi_q + CW'(1);
            if (rdi_q + CW'(1) < cnt_q) begin
              st_d = S_SHDN;
            end else begin
              cnt_d = cnt_q - CW'(1);
              st_d  = S_FIN;
            end
          end
        end else if (idx_q < cnt_q) begin
          seg_re = 1'b1;
          pend_d = 1'b1;
          rdi_d  = idx_q;
          idx_d  = idx_q + CW'(1);
        end else begin
          rst_d = ffha_pkg::ST_NOFIT;
          st_d  = S_FIN;
        end
      end

      S_FLEN: begin
        // Clip the stored length to the heap end
        len_d = lenc[LW-1:0];
        if (lenc == '0) begin
          rst_d = ffha_pkg::ST_BADADDR;
          st_d  = S_FIN;
        end else begin
          st_d = S_FSCAN;
        end
      end

      S_FSCAN: begin
        pv_d = ev_pv;
        ps_d = e_ps;
        pl_d = e_pl;
        if (has_cur || (idx_q >= cnt_q)) begin
          // Insertion point found: check overlap, then merge or insert
          al_wa = bs_q;
          st_d  = S_FIN;
          rst_d = ffha_pkg::ST_OK;
          if (bad) begin
            rst_d = ffha_pkg::ST_BADADDR;
          end else if (mp && mn) begin
            al_we  = 1'b1;
            seg_we = 1'b1;
            seg_wa = prv_i[IW-1:0];
            seg_wd = {e_ps, e_pl + len_q + cur_l};
            idx_d  = ins_i + CW'(1);
            if (ins_i + CW'(1) < cnt_q) begin
              st_d = S_SHDN;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end else if (mp) begin
            al_we  = 1'b1;
            seg_we = 1'b1;
            seg_wa = prv_i[IW-1:0];
            seg_wd = {e_ps, e_pl + len_q};
          end else if (mn) begin
            al_we  = 1'b1;
            seg_we = 1'b1;
            seg_wa = ins_i[IW-1:0];
            seg_wd = {bs_q, cur_l + len_q};
          end else if (cnt_q >= MAXC) begin
            rst_d = ffha_pkg::ST_FULL;
          end else begin
            al_we  = 1'b1;
            hit_d  = ins_i;
            idx_d  = cnt_q - CW'(1);
            more_d = (cnt_q > ins_i);
            st_d   = S_SHUP;
          end
        end else begin
          seg_re = 1'b1;
          pend_d = 1'b1;
          rdi_d  = idx_q;
          idx_d  = idx_q + CW'(1);
        end
      end

      S_SHDN: begin
        // Move each entry one place down over the dropped one
        if (pend_q) begin
          seg_we = 1'b1;
          seg_wa = rdi_q[IW-1:0] - IW'(1);
          seg_wd = {cur_s, cur_l};
        end
        if (idx_q < cnt_q) begin
          seg_re = 1'b1;
          pend_d = 1'b1;
          rdi_d  = idx_q;
          idx_d  = idx_q + CW'(1);
        end else if (!pend_q) begin
          cnt_d = cnt_q - CW'(1);
          st_d  = S_FIN;
        end
      end

      S_SHUP: begin
        // Move the tail one place up, then write the new segment
        if (pend_q) begin
          seg_we = 1'b1;
          seg_wa = rdi_q[IW-1:0] + IW'(1);
          seg_wd = {cur_s, cur_l};
        end
        if (more_q) begin
          seg_re = 1'b1;
          pend_d = 1'b1;
          rdi_d  = idx_q;
          idx_d  = idx_q - CW'(1);
          more_d = (idx_q != hit_q);
        end else if (!pend_q) begin
          seg_we = 1'b1;
          seg_wa = hit_q[IW-1:0];
          seg_wd = {bs_q, len_q};
          cnt_d  = cnt_q + CW'(1);
          st_d   = S_FIN;
        end
      end

      S_FIN: begin
        if (!ov_q || rsp_o.ready) begin
          st_d = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
    rd0_d = seg_re && (seg_ra == '0) && !seg0_wr_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      cnt_q     <= CW'(1);
      pend_q    <= 1'b0;
      more_q    <= 1'b0;
      rd0_q     <= 1'b0;
      seg0_wr_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      more_q <= more_d;
      rd0_q  <= rd0_d;
      if (seg_we && seg_wa == '0) begin
        seg0_wr_q <= 1'b1;
      end
      if (st_q == S_FIN && (!ov_q || rsp_o.ready)) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    rdi_q  <= rdi_d;
    hit_q  <= hit_d;
    need_q <= need_d;
    bs_q   <= bs_d;
    len_q  <= len_d;
    pv_q   <= pv_d;
    ps_q   <= ps_d;
    pl_q   <= pl_d;
    rst_q  <= rst_d;
    radr_q <= radr_d;
    if (st_q == S_FIN && (!ov_q || rsp_o.ready)) begin
      ost_q  <= rst_q;
      oadr_q <= (rst_q == ffha_pkg::ST_OK) ? radr_q : '0;
    end
  end
endmodule
`default_nettype wire
